// File: rtl/core/sdt_pkg.sv
// package for the sorted deque table core
// shared constants: default sizes, port widths, operation kinds and status codes
// no dependencies
`timescale 1ns / 1ps

package sdt_pkg;

    // default sizes for the top level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 16;

    // fixed port widths
    localparam int KIND_W    = 3;
    localparam int OPERAND_W = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_ADD_FRONT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_REAR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REM_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REM_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SORT_INS   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REM_VALUE  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: rtl/core/sorted_deque_table_core.sv
// top level of the sorted deque table core: sequencer, bookkeeping, result word
// depends on sdt_pkg and sdt_store
// one memory port walks the store an entry at a time
`timescale 1ns / 1ps

// Bounded ordered list of up to DEPTH signed elements kept in a circular store.
// A command word is taken when start is high and busy is low; exactly one result
// word follows, shown for a single cycle with done high, and it cannot be held
// off by the receiver. Add front, add rear, kind 7 and any rejected command go
// straight to the write-back and result step; remove front or rear first reads
// the end entry. Sorted insert, remove value and search on a non-empty list
// first scan the held elements in order, one read per cycle with the compare in
// the cycle after each read, then insert and remove value move the trailing
// entries one per cycle where needed, then write back and report. The move only
// covers the tail from where the scan stopped; both walks are paced by the single
// read and single write port of the entry store. busy stays high throughout; a
// new command may be given in the cycle that done is high.
module sorted_deque_table_core #(
    parameter int DEPTH      = sdt_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = sdt_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sdt_pkg::KIND_W-1:0]          kind,
    input  logic signed [sdt_pkg::OPERAND_W-1:0] operand_value,
    output logic                                done,
    output logic signed [sdt_pkg::OPERAND_W-1:0] removed_value,
    output logic                                found,
    output logic [sdt_pkg::STATUS_W-1:0]        status,
    output logic [sdt_pkg::COUNT_W-1:0]         element_count
);
    import sdt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FETCH  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    // physical slot of a logical position
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [ELEM_WIDTH-1:0]   elem_reg, elem_next;
    logic [STATUS_W-1:0]     st_reg, st_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        tgt_reg, tgt_next;
    logic                    hit_reg, hit_next;
    logic [CNT_W-1:0]        rd_pos_reg, rd_pos_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic                    up_reg, up_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]        cmp_pos_reg, cmp_pos_next;
    logic                    wb_valid_reg, wb_valid_next;
    logic [CNT_W-1:0]        wb_pos_reg, wb_pos_next;

    logic                    done_reg, done_next;
    logic [OPERAND_W-1:0]    removed_reg, removed_next;
    logic                    found_reg, found_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [COUNT_W-1:0]      count_out_reg, count_out_next;

    // store ports
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [ELEM_WIDTH-1:0]   mem_wdata;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    logic [ELEM_WIDTH-1:0]   mem_rdata;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic [IDX_W-1:0]        head_dec;
    logic [IDX_W-1:0]        head_inc;
    logic signed [ELEM_WIDTH-1:0] operand_elem;
    logic                    scan_hit;

    sdt_store #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign full   = (count_reg >= CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // operand sign-extended or cut down to the element width
    assign operand_elem = ELEM_WIDTH'(operand_value);

    // circular head moves
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // compare of the scanned entry against the operand
    always_comb
    begin
        if (kind_reg == KIND_SORT_INS)
        begin
            if (cmp_pos_reg == '0)
            begin
                scan_hit = $signed(elem_reg) < $signed(mem_rdata);
            end
            else
            begin
                scan_hit = !($signed(mem_rdata) < $signed(elem_reg));
            end
        end
        else
        begin
            scan_hit = (mem_rdata == elem_reg);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        elem_next      = elem_reg;
        st_next        = st_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        tgt_next       = tgt_reg;
        hit_next       = hit_reg;
        rd_pos_next    = rd_pos_reg;
        left_next      = left_reg;
        up_next        = up_reg;
        cmp_valid_next = 1'b0;
        cmp_pos_next   = cmp_pos_reg;
        wb_valid_next  = 1'b0;
        wb_pos_next    = wb_pos_reg;
        done_next      = 1'b0;
        removed_next   = removed_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_of(head_reg, wb_pos_reg);
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = slot_of(head_reg, rd_pos_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = kind;
                    elem_next   = operand_elem;
                    tgt_next    = '0;
                    hit_next    = 1'b0;
                    rd_pos_next = '0;
                    st_next     = ST_OK;
                    priority if ((kind == KIND_ADD_FRONT || kind == KIND_ADD_REAR
                                  || kind == KIND_SORT_INS) && full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FINISH;
                    end
                    else if ((kind == KIND_REM_FRONT || kind == KIND_REM_REAR) && empty)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_FINISH;
                    end
                    else if (kind == KIND_REM_FRONT || kind == KIND_REM_REAR)
                    begin
                        state_next = S_FETCH;
                    end
                    else if ((kind == KIND_SORT_INS || kind == KIND_REM_VALUE
                              || kind == KIND_SEARCH) && !empty)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            // read the element at the front or the rear
            S_FETCH:
            begin
                mem_re = 1'b1;
                if (kind_reg == KIND_REM_FRONT)
                begin
                    mem_raddr = head_reg;
                end
                else
                begin
                    mem_raddr = slot_of(head_reg, count_reg - 1'b1);
                end
                state_next = S_FINISH;
            end

            // in-order walk, read one ahead of the compare
            S_SCAN:
            begin
                if (rd_pos_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    rd_pos_next    = rd_pos_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = rd_pos_reg;
                end
                if (cmp_valid_reg && (scan_hit || cmp_pos_reg == count_reg - 1'b1))
                begin
                    cmp_valid_next = 1'b0;
                    hit_next       = scan_hit;
                    tgt_next       = scan_hit ? cmp_pos_reg : count_reg;
                    state_next     = S_FINISH;
                    // removal of a middle entry: pull the tail down
                    if (kind_reg == KIND_REM_VALUE && scan_hit && cmp_pos_reg != '0
                        && (cmp_pos_reg + 1'b1) < count_reg)
                    begin
                        up_next     = 1'b0;
                        rd_pos_next = cmp_pos_reg + 1'b1;
                        left_next   = count_reg - 1'b1 - cmp_pos_reg;
                        state_next  = S_SHIFT;
                    end
                    // insert after the front: push the tail up
                    else if (kind_reg == KIND_SORT_INS && scan_hit && cmp_pos_reg != '0)
                    begin
                        up_next     = 1'b1;
                        rd_pos_next = count_reg - 1'b1;
                        left_next   = count_reg - cmp_pos_reg;
                        state_next  = S_SHIFT;
                    end
                end
            end

            // entry move, read then write back one slot over
            S_SHIFT:
            begin
                if (left_reg != '0)
                begin
                    mem_re        = 1'b1;
                    left_next     = left_reg - 1'b1;
                    wb_valid_next = 1'b1;
                    rd_pos_next   = up_reg ? rd_pos_reg - 1'b1 : rd_pos_reg + 1'b1;
                    wb_pos_next   = up_reg ? rd_pos_reg + 1'b1 : rd_pos_reg - 1'b1;
                end
                if (wb_valid_reg)
                begin
                    mem_we = 1'b1;
                end
                if (left_reg == '0 && !wb_valid_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            // write back, bookkeeping and result word
            S_FINISH:
            begin
                removed_next = '0;
                found_next   = 1'b0;
                status_next  = st_reg;
                mem_wdata    = elem_reg;
                if (st_reg == ST_OK)
                begin
                    unique case (kind_reg)
                        KIND_ADD_FRONT:
                        begin
                            head_next  = head_dec;
                            mem_we     = 1'b1;
                            mem_waddr  = head_dec;
                            count_next = count_reg + 1'b1;
                        end
                        KIND_ADD_REAR:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_of(head_reg, count_reg);
                            count_next = count_reg + 1'b1;
                        end
                        KIND_REM_FRONT:
                        begin
                            removed_next = OPERAND_W'($signed(mem_rdata));
                            head_next    = head_inc;
                            count_next   = count_reg - 1'b1;
                        end
                        KIND_REM_REAR:
                        begin
                            removed_next = OPERAND_W'($signed(mem_rdata));
                            count_next   = count_reg - 1'b1;
                        end
                        KIND_SORT_INS:
                        begin
                            mem_we = 1'b1;
                            if (tgt_reg == '0)
                            begin
                                head_next = head_dec;
                                mem_waddr = head_dec;
                            end
                            else
                            begin
                                mem_waddr = slot_of(head_reg, tgt_reg);
                            end
                            count_next = count_reg + 1'b1;
                        end
                        KIND_REM_VALUE:
                        begin
                            found_next = hit_reg;
                            if (hit_reg)
                            begin
                                if (tgt_reg == '0)
                                begin
                                    head_next = head_inc;
                                end
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            found_next = hit_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                count_out_next = COUNT_W'(count_next);
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wb_valid_reg  <= wb_valid_next;
            done_reg      <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        elem_reg      <= elem_next;
        st_reg        <= st_next;
        tgt_reg       <= tgt_next;
        hit_reg       <= hit_next;
        rd_pos_reg    <= rd_pos_next;
        left_reg      <= left_next;
        up_reg        <= up_next;
        cmp_pos_reg   <= cmp_pos_next;
        wb_pos_reg    <= wb_pos_next;
        removed_reg   <= removed_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign found         = found_reg;
    assign status        = status_reg;
    assign element_count = count_out_reg;

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while still busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (removed_value == '0 && !found))
        else $error("rejected command returned data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (element_count == COUNT_W'(DEPTH)))
        else $error("full status with store not full");

endmodule

// File: rtl/core/sdt_store.sv
// entry store for the sorted deque table core
// single write port, single read port with registered read data
// depends on sdt_pkg for default sizes
`timescale 1ns / 1ps

module sdt_store #(
    parameter int DEPTH      = sdt_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = sdt_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [ELEM_WIDTH-1:0]       wdata,
    input  logic                        re,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [ELEM_WIDTH-1:0]       rdata
);
    import sdt_pkg::*;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
